// ----- sv/uvr_pkg.sv -----
// Shared types and constants for the UTF-8 validate/replace block.
// No dependencies; imported by uvr_decode, uvr_burst and the top level.
`default_nettype none

package uvr_pkg;

    localparam int BURST_MAX   = 12;
    localparam int BURST_W     = 8 * BURST_MAX;
    localparam int CNT_W       = $clog2(BURST_MAX + 1);
    localparam int ACC_W       = 21;

    // U+FFFD in UTF-8, first byte in the low bits
    localparam logic [23:0] REPL_SEQ = 24'hBDBFEF;

    localparam logic [ACC_W-1:0] MIN_CP2 = 21'h00080;
    localparam logic [ACC_W-1:0] MIN_CP3 = 21'h00800;
    localparam logic [ACC_W-1:0] MIN_CP4 = 21'h10000;

    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    typedef logic [2:0][7:0] held_t;

    typedef struct packed {
        logic [1:0]       pending;
        logic [2:0]       seq_len;
        logic [ACC_W-1:0] acc;
    } ctl_state_t;

    // bytes go out from the low end first
    typedef struct packed {
        logic [BURST_W-1:0] bytes;
        logic [CNT_W-1:0]   count;
        logic               present;
        logic               done;
    } burst_t;

endpackage

`default_nettype wire

// ----- sv/uvr_decode.sv -----
// Per-beat decode: next sequence state and the burst of result bytes.
// Depends on uvr_pkg.
`default_nettype none

module uvr_decode (
    input  wire logic                in_byte_v [0:0],
    input  wire logic [7:0]          in_byte,
    input  wire logic                has_byte,
    input  wire logic                string_end,
    input  wire logic                replace_mode,
    input  wire uvr_pkg::ctl_state_t ctl,
    input  wire uvr_pkg::held_t      held,
    output uvr_pkg::ctl_state_t      ctl_next,
    output uvr_pkg::held_t           held_next,
    output uvr_pkg::burst_t          burst
);
    import uvr_pkg::*;

    logic               is_cont;
    logic [1:0]         pend_dec;
    logic [ACC_W-1:0]   acc_upd;
    logic [ACC_W-1:0]   cont_bits;
    logic [3:0]         idx_w;
    logic [2:0]         len_eff;
    logic               overlong;
    logic [BURST_W-1:0] vec;
    logic [CNT_W-1:0]   n;

    always_comb
    begin
        is_cont   = (in_byte[7:6] == CONT_TAG);
        pend_dec  = ctl.pending - 2'd1;
        case (pend_dec)
            2'd0:    cont_bits = {15'd0, in_byte[5:0]};
            2'd1:    cont_bits = {9'd0, in_byte[5:0], 6'd0};
            default: cont_bits = {3'd0, in_byte[5:0], 12'd0};
        endcase
        acc_upd   = ctl.acc | cont_bits;
        idx_w     = {1'b0, ctl.seq_len} - 4'd1 - {2'd0, pend_dec};
        len_eff   = (ctl.seq_len < 3'd2 || ctl.seq_len > 3'd4) ? 3'd2 : ctl.seq_len;
        case (len_eff)
            3'd2:    overlong = (acc_upd < MIN_CP2);
            3'd3:    overlong = (acc_upd < MIN_CP3);
            default: overlong = (acc_upd < MIN_CP4);
        endcase

        ctl_next  = ctl;
        held_next = held;
        vec       = '0;
        n         = '0;

        if (has_byte && in_byte_v[0])
        begin
            if (ctl.pending != 2'd0 && !is_cont)
            begin
                ctl_next.pending = 2'd0;
                if (replace_mode)
                begin
                    vec[23:0] = REPL_SEQ;
                    n         = CNT_W'(3);
                end
            end
            if (ctl.pending == 2'd0 || !is_cont)
            begin
                if (!in_byte[7])
                begin
                    vec = vec | (BURST_W'(in_byte) << {n, 3'b000});
                    n   = n + CNT_W'(1);
                end
                else if (in_byte[7:5] == LEAD2_TAG)
                begin
                    ctl_next.seq_len = 3'd2;
                    ctl_next.pending = 2'd1;
                    ctl_next.acc     = {10'd0, in_byte[4:0], 6'd0};
                    held_next[0]     = in_byte;
                end
                else if (in_byte[7:4] == LEAD3_TAG)
                begin
                    ctl_next.seq_len = 3'd3;
                    ctl_next.pending = 2'd2;
                    ctl_next.acc     = {5'd0, in_byte[3:0], 12'd0};
                    held_next[0]     = in_byte;
                end
                else if (in_byte[7:3] == LEAD4_TAG)
                begin
                    ctl_next.seq_len = 3'd4;
                    ctl_next.pending = 2'd3;
                    ctl_next.acc     = {in_byte[2:0], 18'd0};
                    held_next[0]     = in_byte;
                end
                else if (replace_mode)
                begin
                    vec = vec | (BURST_W'(REPL_SEQ) << {n, 3'b000});
                    n   = n + CNT_W'(3);
                end
            end
            else
            begin
                ctl_next.pending = pend_dec;
                ctl_next.acc     = acc_upd;
                if (pend_dec != 2'd0)
                begin
                    if (!idx_w[3] && idx_w[2:0] < 3'd3)
                        held_next[idx_w[1:0]] = in_byte;
                end
                else
                begin
                    ctl_next.acc = '0;
                    if (overlong)
                    begin
                        if (replace_mode)
                        begin
                            case (len_eff)
                                3'd2:
                                begin
                                    vec = BURST_W'({2{REPL_SEQ}});
                                    n   = CNT_W'(6);
                                end
                                3'd3:
                                begin
                                    vec = BURST_W'({3{REPL_SEQ}});
                                    n   = CNT_W'(9);
                                end
                                default:
                                begin
                                    vec = BURST_W'({4{REPL_SEQ}});
                                    n   = CNT_W'(12);
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        case (len_eff)
                            3'd2:
                            begin
                                vec = BURST_W'({in_byte, held[0]});
                                n   = CNT_W'(2);
                            end
                            3'd3:
                            begin
                                vec = BURST_W'({in_byte, held[1], held[0]});
                                n   = CNT_W'(3);
                            end
                            default:
                            begin
                                vec = BURST_W'({in_byte, held[2], held[1], held[0]});
                                n   = CNT_W'(4);
                            end
                        endcase
                    end
                end
            end
        end

        burst.present = 1'b1;
        burst.done    = 1'b0;
        if (string_end)
        begin
            if (ctl_next.pending != 2'd0 && replace_mode)
            begin
                vec = vec | (BURST_W'(REPL_SEQ) << {n, 3'b000});
                n   = n + CNT_W'(3);
            end
            ctl_next = '0;
            if (n == '0)
            begin
                n             = CNT_W'(1);
                burst.present = 1'b0;
            end
            burst.done = 1'b1;
        end
        burst.bytes = vec;
        burst.count = n;
    end

endmodule

`default_nettype wire

// ----- sv/uvr_burst.sv -----
// Result register: holds one beat's burst of bytes and shifts it out.
// Depends on uvr_pkg.
`default_nettype none

module uvr_burst (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire uvr_pkg::burst_t burst,
    output logic                 free,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           out_byte,
    output logic                 byte_present,
    output logic                 string_done,
    output logic                 last
);
    import uvr_pkg::*;

    logic [BURST_W-1:0] bytes_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               present_reg;
    logic               done_reg;
    logic               pop;

    assign out_valid    = (cnt_reg != '0);
    assign pop          = out_valid && out_ready;
    assign free         = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && out_ready);
    assign out_byte     = bytes_reg[7:0];
    assign last         = (cnt_reg == CNT_W'(1));
    assign byte_present = present_reg;
    assign string_done  = done_reg && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load && free)
        begin
            cnt_reg <= burst.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            bytes_reg   <= burst.bytes;
            present_reg <= burst.present;
            done_reg    <= burst.done;
        end
        else if (pop)
        begin
            bytes_reg <= bytes_reg >> 8;
        end
    end

endmodule

`default_nettype wire

// ----- sv/utf8_validate_replace.sv -----
// Top level of the UTF-8 validate/replace block: input register, sequence
// state, decode and result register. Depends on uvr_pkg, uvr_decode, uvr_burst.
//
// Usage:
//   Input beats (in_byte, has_byte, string_end) enter on in_valid/in_ready.
//   Result beats (out_byte, byte_present, string_done, last) leave on
//   out_valid/out_ready; last marks the final result of one input beat and
//   string_done the final result of a string.
//   replace_mode is written on cfg_valid/cfg_ready (always ready); the user must
//   write it only while idle, which the block does not enforce. It resets to 1.
// An input beat passes the input register, then the result register.
// Throughput: one input beat per cycle while each beat yields at most one
//   result and out_ready is high. A beat with k results (up to 12) holds the
//   result register until all k leave, one per cycle while out_ready is high;
//   beats with no result pass the input register without waiting on output.
// Reset clears the pending sequence and both valid flags, and sets
//   replace_mode to 1.
// When the receiver stalls, the result register holds, then the input
//   register fills and in_ready drops.
`default_nettype none

module utf8_validate_replace (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       has_byte,
    input  wire logic       string_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_present,
    output logic            string_done,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);
    import uvr_pkg::*;

    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_has_reg;
    logic       stg_end_reg;
    logic       replace_mode_reg;
    ctl_state_t ctl_reg;
    ctl_state_t ctl_next;
    held_t      held_reg;
    held_t      held_next;
    burst_t     burst;
    logic       burst_free;
    logic       advance;
    logic       stg_v [0:0];

    assign cfg_ready = 1'b1;
    assign advance   = stg_valid_reg && (burst_free || burst.count == '0);
    assign in_ready  = !stg_valid_reg || advance;
    assign stg_v[0]  = stg_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg    <= 1'b0;
            replace_mode_reg <= 1'b1;
            ctl_reg          <= '0;
        end
        else
        begin
            if (in_ready)
                stg_valid_reg <= in_valid;
            if (cfg_valid && cfg_ready)
                replace_mode_reg <= cfg_data;
            if (advance)
                ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_byte_reg <= in_byte;
            stg_has_reg  <= has_byte;
            stg_end_reg  <= string_end;
        end
        if (advance)
            held_reg <= held_next;
    end

    uvr_decode u_decode (
        .in_byte_v    (stg_v),
        .in_byte      (stg_byte_reg),
        .has_byte     (stg_has_reg),
        .string_end   (stg_end_reg),
        .replace_mode (replace_mode_reg),
        .ctl          (ctl_reg),
        .held         (held_reg),
        .ctl_next     (ctl_next),
        .held_next    (held_next),
        .burst        (burst)
    );

    uvr_burst u_burst (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && burst.count != '0),
        .burst        (burst),
        .free         (burst_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .string_done  (string_done),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- sv/uvr_checker.sv -----
// Port-level checker for utf8_validate_replace, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module uvr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       byte_present,
    input wire logic       string_done,
    input wire logic       last
);

    // stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(byte_present) && $stable(string_done) && $stable(last))
        else $error("result beat changed while stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> last)
        else $error("string_done without last");

    a_marker_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_present |-> string_done && last)
        else $error("end-only beat not closing a string");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_present |-> out_byte == 8'h00)
        else $error("end-only beat carries a byte");

endmodule

bind utf8_validate_replace uvr_checker u_uvr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .string_done  (string_done),
    .last         (last)
);

`default_nettype wire

// ----- sim/tb_utf8_validate_replace.sv -----
`timescale 1ns / 100ps
// Testbench for utf8_validate_replace: directed strings in replace mode, random
// ones in both modes, checked beat by beat against a behavioral predictor.
// Depends on uvr_pkg and the utf8_validate_replace RTL.

module tb_utf8_validate_replace;
    import uvr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       done;
        logic       lst;
    } beat_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte      = 8'h00;
    logic       has_byte     = 1'b0;
    logic       string_end   = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       string_done;
    logic       last;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic       cfg_data     = 1'b0;

    logic        m_replace = 1'b1;
    logic [1:0]  m_pend    = 2'd0;
    logic [2:0]  m_len     = 3'd0;
    logic [20:0] m_acc     = 21'd0;
    logic [7:0]  m_held [3];

    beat_t sanitized_q [$];
    beat_t burst_q [$];
    beat_t beat_want;

    int  err_cnt     = 0;
    int  items_sent  = 0;
    int  quiet_cnt   = 0;
    bit  no_idle     = 1'b0;

    utf8_validate_replace u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .has_byte     (has_byte),
        .string_end   (string_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .string_done  (string_done),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic push_byte(input logic [7:0] b);
        beat_t r;
        r.data    = b;
        r.present = 1'b1;
        r.done    = 1'b0;
        r.lst     = 1'b0;
        burst_q.push_back(r);
    endtask

    task automatic push_fffd();
        if (m_replace)
        begin
            push_byte(REPL_SEQ[7:0]);
            push_byte(REPL_SEQ[15:8]);
            push_byte(REPL_SEQ[23:16]);
        end
    endtask

    task automatic take_lead(input logic [7:0] b);
        if (b[7] == 1'b0)
            push_byte(b);
        else if (b[7:5] == LEAD2_TAG)
        begin
            m_len     = 3'd2;
            m_pend    = 2'd1;
            m_acc     = {10'd0, b[4:0], 6'd0};
            m_held[0] = b;
        end
        else if (b[7:4] == LEAD3_TAG)
        begin
            m_len     = 3'd3;
            m_pend    = 2'd2;
            m_acc     = {5'd0, b[3:0], 12'd0};
            m_held[0] = b;
        end
        else if (b[7:3] == LEAD4_TAG)
        begin
            m_len     = 3'd4;
            m_pend    = 2'd3;
            m_acc     = {b[2:0], 18'd0};
            m_held[0] = b;
        end
        else
            push_fffd();
    endtask

    task automatic take_byte(input logic [7:0] b);
        int          idx;
        int          k;
        logic [20:0] min_cp;
        if (m_pend == 2'd0)
            take_lead(b);
        else if (b[7:6] != CONT_TAG)
        begin
            m_pend = 2'd0;
            push_fffd();
            take_lead(b);
        end
        else
        begin
            m_pend = m_pend - 2'd1;
            m_acc  = m_acc | ({15'd0, b[5:0]} << (6 * m_pend));
            if (m_pend != 2'd0)
            begin
                idx = int'(m_len) - 1 - int'(m_pend);
                m_held[idx] = b;
            end
            else
            begin
                case (m_len)
                    3'd3:    min_cp = MIN_CP3;
                    3'd4:    min_cp = MIN_CP4;
                    default: min_cp = MIN_CP2;
                endcase
                if (m_acc < min_cp)
                    repeat (m_len) push_fffd();
                else
                begin
                    for (k = 0; k < int'(m_len) - 1; k++)
                        push_byte(m_held[k]);
                    push_byte(b);
                end
                m_acc = 21'd0;
            end
        end
    endtask

    task automatic sanitize(input logic [7:0] b, input logic hb, input logic se);
        beat_t r;
        burst_q.delete();
        if (hb)
            take_byte(b);
        if (se)
        begin
            if (m_pend != 2'd0)
                push_fffd();
            m_pend = 2'd0;
            m_len  = 3'd0;
            m_acc  = 21'd0;
            if (burst_q.size() == 0)
            begin
                r = '0;
                burst_q.push_back(r);
            end
            r = burst_q.pop_back();
            r.done = 1'b1;
            burst_q.push_back(r);
        end
        if (burst_q.size() != 0)
        begin
            r = burst_q.pop_back();
            r.lst = 1'b1;
            burst_q.push_back(r);
        end
        foreach (burst_q[i])
            sanitized_q.push_back(burst_q[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (err_cnt < 40)
            $display("mismatch %s: got %02h, want %02h", what, got, want);
        err_cnt++;
    endtask

    // entered and left at a rising edge
    task automatic send_item(input logic [7:0] b, input logic hb, input logic se);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        has_byte   <= hb;
        string_end <= se;
        do
            @(posedge clk);
        while (!in_ready);
        sanitize(b, hb, se);
        if (hb || se)
            items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sanitized_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        m_replace = mode;
    endtask

    task automatic test_ascii_and_markers();
        logic [31:0] rnd;
        rnd = $urandom;
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(rnd[7:0], 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_valid_sequences();
        send_item(8'hC3, 1'b1, 1'b0);
        send_item(8'hA9, 1'b1, 1'b1);
        send_item(8'hE2, 1'b1, 1'b0);
        send_item(8'h82, 1'b1, 1'b0);
        send_item(8'hAC, 1'b1, 1'b0);
        // above U+10FFFF, passed through
        send_item(8'hF4, 1'b1, 1'b0);
        send_item(8'h90, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
    endtask

    task automatic test_invalid_sequences();
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        // bad continuation, then reused as lead
        send_item(8'hC3, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        // overlong forms
        send_item(8'hC0, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hF0, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        // cut short by the string end
        send_item(8'hE2, 1'b1, 1'b0);
        send_item(8'h82, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic send_random_string();
        logic [7:0]  seq [$];
        logic [31:0] rnd;
        int          nch;
        int          kind;
        int          clen;
        int          i;
        bit          end_on_byte;
        nch = $urandom_range(0, 6);
        repeat (nch)
        begin
            kind = $urandom_range(0, 99);
            rnd  = $urandom;
            if (kind < 35)
                seq.push_back({1'b0, rnd[6:0]});
            else if (kind < 85)
            begin
                clen = $urandom_range(2, 4);
                case (clen)
                    2:       seq.push_back({LEAD2_TAG, rnd[4:0]});
                    3:       seq.push_back({LEAD3_TAG, rnd[3:0]});
                    default: seq.push_back({LEAD4_TAG, rnd[2:0]});
                endcase
                // a few are truncated
                if (kind >= 80)
                    clen--;
                for (i = 1; i < clen; i++)
                begin
                    rnd = $urandom;
                    seq.push_back({CONT_TAG, rnd[13:8]});
                end
            end
            else
                seq.push_back(rnd[7:0]);
        end
        end_on_byte = ($urandom_range(0, 1) == 1) && (seq.size() != 0);
        for (i = 0; i < seq.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                rnd = $urandom;
                send_item(rnd[7:0], 1'b0, 1'b0);
            end
            send_item(seq[i], 1'b1, end_on_byte && (i == seq.size() - 1));
        end
        if (!end_on_byte)
        begin
            rnd = $urandom;
            send_item(rnd[7:0], 1'b0, 1'b1);
        end
    endtask

    task automatic test_random_strings(input int target, input bit quiet);
        int start;
        no_idle = quiet;
        start = items_sent;
        while (items_sent - start < target)
            send_random_string();
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b1);
        test_ascii_and_markers();
        test_valid_sequences();
        test_invalid_sequences();
        write_mode(1'b0);
        test_random_strings(80, 1'b0);
        write_mode(1'b1);
        test_random_strings(90, 1'b0);
        test_random_strings(35, 1'b1);
        write_mode(1'b0);
        test_random_strings(25, 1'b1);
        write_mode(1'b1);
        test_random_strings(30, 1'b0);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int w;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            w = no_idle ? 0 : $urandom_range(0, 3);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (sanitized_q.size() == 0)
                report_mismatch("unexpected beat", out_byte, 8'h00);
            else
            begin
                beat_want = sanitized_q.pop_front();
                if (out_byte !== beat_want.data)
                    report_mismatch("out_byte", out_byte, beat_want.data);
                if (byte_present !== beat_want.present)
                    report_mismatch("byte_present", {7'd0, byte_present},
                                    {7'd0, beat_want.present});
                if (string_done !== beat_want.done)
                    report_mismatch("string_done", {7'd0, string_done},
                                    {7'd0, beat_want.done});
                if (last !== beat_want.lst)
                    report_mismatch("last", {7'd0, last}, {7'd0, beat_want.lst});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cnt <= 0;
        else if (quiet_cnt < WATCHDOG_LIMIT)
            quiet_cnt <= quiet_cnt + 1;
        else
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
